/* hdl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: serial packet deframer shared definitions
// Header byte constants, command codes, register indexes and the item and
// result records passed between the deframer stages.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned HdrLen  = 16;
  localparam int unsigned WinLen  = HdrLen - 1;  // last header byte is never stored
  localparam int unsigned FillW   = $clog2(HdrLen);

  // fixed header bytes
  localparam logic [7:0] SYNC_HI    = 8'hA5;
  localparam logic [7:0] SYNC_LO    = 8'h5A;
  localparam logic [7:0] TYPE_HI    = 8'h01;
  localparam logic [7:0] VER_HI     = 8'h00;
  localparam logic [7:0] VER_LO     = 8'h01;
  localparam logic [7:0] MAGIC_B0   = 8'h78;
  localparam logic [7:0] MAGIC_B1   = 8'h56;
  localparam logic [7:0] MAGIC_B2   = 8'h34;
  localparam logic [7:0] MAGIC_B3   = 8'h12;

  // type low byte codes
  localparam logic [7:0] TYPE_PLAY_DATA = 8'h10;
  localparam logic [7:0] TYPE_PLAY_END  = 8'h11;
  localparam logic [7:0] TYPE_START     = 8'h08;
  localparam logic [7:0] TYPE_STOP      = 8'h06;
  localparam logic [7:0] TYPE_QUERY     = 8'h02;
  localparam logic [7:0] TYPE_PROMPT    = 8'h0B;
  localparam logic [7:0] TYPE_LOOP      = 8'h0E;

  localparam logic [15:0] RESET_MAX_PAYLOAD = 16'd2048;

  typedef enum logic [2:0] {
    KIND_OTHER     = 3'd0,
    KIND_PLAY_DATA = 3'd1,
    KIND_PLAY_END  = 3'd2,
    KIND_START     = 3'd3,
    KIND_STOP      = 3'd4,
    KIND_QUERY     = 3'd5,
    KIND_PROMPT    = 3'd6,
    KIND_LOOP      = 3'd7
  } spd_kind_e;

  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_PROMPT_ON   = 2'd1
  } spd_cfg_idx_e;

  typedef struct packed {
    logic       line_error;
    logic [7:0] rx_byte;
  } spd_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_done;
    logic        packet_ok;
    logic [2:0]  packet_kind;
    logic [31:0] bad_packets;
  } spd_result_t;

endpackage

/* hdl/spd_in_stage.sv */
// ----------------------------------------------------------------------------
// spd_in_stage: input register
// Holds one received byte request until the core stage takes it.
// ----------------------------------------------------------------------------
module spd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  spd_pkg::spd_item_t s_item_i,
  output logic              s_ready_o,
  input  logic              advance_i,
  output logic              item_valid_o,
  output spd_pkg::spd_item_t item_o
);
  import spd_pkg::*;

  logic      valid_q, valid_d;
  spd_item_t item_q;

  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* hdl/spd_core.sv */
// ----------------------------------------------------------------------------
// spd_core: framing state and verdict logic
// Header window, payload counter and checksum, bad packet counter and the
// configuration registers. Framing state moves on when the core takes an item.
// ----------------------------------------------------------------------------
module spd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 advance_i,
  input  spd_pkg::spd_item_t   item_i,
  output spd_pkg::spd_result_t res_o
);
  import spd_pkg::*;

  logic [15:0]      max_payload_q;
  logic             prompt_on_q;

  logic [7:0]       win_q [WinLen];
  logic [7:0]       win_d [WinLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic             in_payload_q, in_payload_d;
  logic [15:0]      left_q, left_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      exp_q, exp_d;
  logic [7:0]       type_q, type_d;
  logic [31:0]      bad_q, bad_d;

  logic [7:0]       rx;
  logic             hdr_match;
  logic [15:0]      hdr_len;
  logic [15:0]      hdr_sum;

  logic             fin;
  logic             fin_ok;
  logic             fin_nonzero;
  logic [15:0]      fin_sum;
  logic [15:0]      fin_exp;
  logic [7:0]       fin_type;
  spd_kind_e        fin_kind;

  assign rx = item_i.rx_byte;

  // checked only when the window holds 15 bytes: the new byte is header byte 15
  assign hdr_match = win_q[0] == SYNC_HI && win_q[1] == SYNC_HI &&
                     win_q[2] == SYNC_LO && win_q[3] == SYNC_LO &&
                     win_q[7] == TYPE_HI && win_q[10] == VER_HI &&
                     win_q[11] == VER_LO && win_q[12] == MAGIC_B0 &&
                     win_q[13] == MAGIC_B1 && win_q[14] == MAGIC_B2 &&
                     rx == MAGIC_B3;
  assign hdr_len = {win_q[9], win_q[8]};
  assign hdr_sum = {win_q[5], win_q[4]};

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    in_payload_d = in_payload_q;
    left_d       = left_q;
    sum_d        = sum_q;
    exp_d        = exp_q;
    type_d       = type_q;
    fin          = 1'b0;
    fin_nonzero  = 1'b1;
    fin_sum      = sum_q;
    fin_exp      = exp_q;
    fin_type     = type_q;
    res_o        = '0;

    if (!item_i.line_error) begin
      if (in_payload_q) begin
        sum_d   = sum_q + {8'd0, rx};
        fin_sum = sum_d;
        if (type_q == TYPE_PLAY_DATA) begin
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = rx;
        end
        left_d = left_q - 16'd1;
        fin    = (left_d == 16'd0);
      end else if (fill_q != FillW'(WinLen)) begin
        win_d[fill_q] = rx;
        fill_d        = fill_q + FillW'(1);
      end else if (!hdr_match || hdr_len > max_payload_q) begin
        // slide by one byte; window stays one short of full
        for (int i = 0; i < WinLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WinLen-1] = rx;
      end else begin
        exp_d        = hdr_sum;
        type_d       = win_q[6];
        sum_d        = 16'd0;
        left_d       = hdr_len;
        in_payload_d = 1'b1;
        fill_d       = '0;
        fin          = (hdr_len == 16'd0);
        fin_nonzero  = 1'b0;
        fin_sum      = 16'd0;
        fin_exp      = hdr_sum;
        fin_type     = win_q[6];
      end
    end

    fin_ok = (fin_sum == fin_exp);

    case (fin_type)
      TYPE_PLAY_DATA: fin_kind = fin_nonzero ? KIND_PLAY_DATA : KIND_OTHER;
      TYPE_PLAY_END:  fin_kind = KIND_PLAY_END;
      TYPE_START:     fin_kind = KIND_START;
      TYPE_STOP:      fin_kind = KIND_STOP;
      TYPE_QUERY:     fin_kind = KIND_QUERY;
      TYPE_PROMPT:    fin_kind = prompt_on_q ? KIND_PROMPT : KIND_OTHER;
      TYPE_LOOP:      fin_kind = prompt_on_q ? KIND_LOOP : KIND_OTHER;
      default:        fin_kind = KIND_OTHER;
    endcase

    bad_d = bad_q;
    if (fin) begin
      res_o.packet_done = 1'b1;
      res_o.packet_ok   = fin_ok;
      res_o.packet_kind = fin_kind;
      if (!fin_ok) begin
        bad_d = bad_q + 32'd1;
      end
      in_payload_d = 1'b0;
      left_d       = 16'd0;
      fill_d       = '0;
    end
    res_o.bad_packets = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= RESET_MAX_PAYLOAD;
      prompt_on_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        CFG_PROMPT_ON:   prompt_on_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      in_payload_q <= 1'b0;
      bad_q        <= '0;
    end else if (advance_i) begin
      fill_q       <= fill_d;
      in_payload_q <= in_payload_d;
      bad_q        <= bad_d;
    end
  end

  // contents below are always written before they are read
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q  <= win_d;
      left_q <= left_d;
      sum_q  <= sum_d;
      exp_q  <= exp_d;
      type_q <= type_d;
    end
  end

endmodule

/* hdl/spd_out_stage.sv */
// ----------------------------------------------------------------------------
// spd_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module spd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  spd_pkg::spd_result_t res_i,
  output logic                 free_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output spd_pkg::spd_result_t res_o
);
  import spd_pkg::*;

  logic        valid_q, valid_d;
  spd_result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

/* hdl/serial_packet_deframer_top.sv */
// Path: a byte request accepted into the input register passes the combinational
// framing logic and is registered in the result register for the master side.
// Throughput: one byte per cycle while the master side takes results; the input
// register, framing logic and result register each move one request per clock.
// Reset (rst_ni low, asynchronous): framing restarts with an empty header window,
// bad packet count zero, max payload 2048, prompt commands off; both stages empty.
// ----------------------------------------------------------------------------
// serial_packet_deframer_top: serial packet deframer
// Drops bytes with line errors, hunts the fixed 16-byte header, checks the
// payload sum and reports a verdict per packet; play-data bytes pass through.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] line_error
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] payload_byte, [8] packet_ok,
                                        // [11:9] packet_kind, [43:12] bad_packets,
                                        // [47:44] zero
  output logic        m_axis_tuser_o,   // [0] payload_valid
  output logic        m_axis_tlast_o    // packet_done
);
  import spd_pkg::*;

  spd_item_t   s_item;
  spd_item_t   item;
  logic        item_valid;
  logic        out_free;
  logic        advance;
  spd_result_t core_res;
  spd_result_t out_res;

  assign cfg_ready_o = 1'b1;

  assign s_item.rx_byte    = s_axis_tdata_i;
  assign s_item.line_error = s_axis_tuser_i;

  assign advance = item_valid && out_free;

  spd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_item_i     (s_item),
    .s_ready_o    (s_axis_tready_o),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  spd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .item_i      (item),
    .res_o       (core_res)
  );

  spd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .res_i     (core_res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (out_res)
  );

  assign m_axis_tdata_o = {4'd0, out_res.bad_packets, out_res.packet_kind,
                           out_res.packet_ok, out_res.payload_byte};
  assign m_axis_tuser_o = out_res.payload_valid;
  assign m_axis_tlast_o = out_res.packet_done;

endmodule
